[rtl/dqls_pkg.sv]
// ----------------------------------------------------------------------------
// dqls_pkg: shared types and constants for the ring-store deque
// Store geometry, request and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dqls_pkg;

  // Store geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  // Fixed field widths on the stream ports
  localparam int REQ_W  = 2;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int OUT_W  = 7;

  // Request codes (code 3 is unused and answers as not found)
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSHED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FOUND    = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    wr_front;
    logic    wr_back;
    logic    start_search;
    logic    search_run;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic last;
    logic out_valid;
  } dp_stat_t;

  // Physical slot of list offset off, taken modulo DEPTH
  function automatic logic [ADDR_W-1:0] ring_slot(input logic [ADDR_W-1:0] head,
                                                 input logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

[rtl/dqls_ctrl.sv]
// ----------------------------------------------------------------------------
// dqls_ctrl: request sequencer
// Decodes each accepted request, issues push and search commands to the
// datapath and decides when a result is loaded into the output register.
// ----------------------------------------------------------------------------
module dqls_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_valid,
  input  logic [dqls_pkg::REQ_W-1:0]  req_type,
  input  logic                        m_ready,
  input  dqls_pkg::dp_stat_t          stat,
  output logic                        s_ready,
  output dqls_pkg::cmd_t              cmd
);
  import dqls_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take a request only when idle and the output register will be free
  assign s_ready = (state == S_IDLE) && (!stat.out_valid || m_ready);
  assign accept  = s_valid && s_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (req_type == REQ_SEARCH) && !stat.empty) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.hit || stat.last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd.wr_front     = 1'b0;
    cmd.wr_back      = 1'b0;
    cmd.start_search = 1'b0;
    cmd.search_run   = 1'b0;
    cmd.out_load     = 1'b0;
    cmd.out_status   = ST_PUSHED;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              cmd.out_load = 1'b1;
              if (stat.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.wr_front   = (req_type == REQ_PUSH_FRONT);
                cmd.wr_back    = (req_type == REQ_PUSH_BACK);
                cmd.out_status = ST_PUSHED;
              end
            end
            REQ_SEARCH: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.start_search = 1'b1;
              end
            end
            default: begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_NOTFOUND;
            end
          endcase
        end
      end
      S_SEARCH: begin
        cmd.search_run = 1'b1;
        if (stat.hit) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_FOUND;
        end else if (stat.last) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_NOTFOUND;
        end
      end
      default: begin
        cmd.out_load = 1'b0;
      end
    endcase
  end

endmodule

[rtl/dqls_datapath.sv]
// ----------------------------------------------------------------------------
// dqls_datapath: ring store, pointers, search walker and result register
// Holds the entry memory with head index and count, walks the list one
// registered memory read per cycle, and keeps the outgoing result.
// ----------------------------------------------------------------------------
module dqls_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  dqls_pkg::cmd_t               cmd,
  input  logic [dqls_pkg::VAL_W-1:0]   value,
  input  logic                         m_ready,
  output dqls_pkg::dp_stat_t           stat,
  output logic                         out_valid,
  output logic [dqls_pkg::STAT_W-1:0]  out_status,
  output logic [dqls_pkg::OUT_W-1:0]   out_position,
  output logic [dqls_pkg::OUT_W-1:0]   out_count
);
  import dqls_pkg::*;

  logic [VAL_W-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] head_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [VAL_W-1:0]  key;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  cmp_idx;
  logic              cmp_valid;
  logic [VAL_W-1:0]  rdata;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;

  // Pointer updates for a push
  always_comb begin
    head_next  = head;
    count_next = count;
    wr_addr    = ring_slot(head, count);
    if (cmd.wr_front) begin
      head_next = (head == '0) ? ADDR_W'(DEPTH - 1) : head - 1'b1;
      wr_addr   = head_next;
    end
    if (cmd.wr_front || cmd.wr_back) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Entry memory write port
  always_ff @(posedge clk) begin
    if (cmd.wr_front || cmd.wr_back) begin
      mem[wr_addr] <= value;
    end
  end

  // Search walker: read offset rd_idx, compare the data in the following cycle
  assign rd_en = cmd.search_run && (rd_idx < count);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[ring_slot(head, rd_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else if (cmd.start_search) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      key    <= value;
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx  <= rd_idx + 1'b1;
      cmp_idx <= rd_idx;
    end
  end

  // Status toward the controller
  assign stat.full      = (count == CNT_W'(DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.hit       = cmp_valid && (rdata == key);
  assign stat.last      = cmp_valid && (cmp_idx == count - 1'b1);
  assign stat.out_valid = out_valid;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status   <= cmd.out_status;
      out_count    <= OUT_W'(count_next);
      out_position <= (cmd.out_status == ST_FOUND) ? OUT_W'(cmp_idx + 1'b1) : '0;
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above store depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_front || cmd.wr_back) |-> !stat.full)
    else $error("push written into a full store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_ready))
    else $error("result register reloaded while still held");

  a_hit_in_list: assert property (@(posedge clk) disable iff (rst)
    stat.hit |-> (cmp_idx < count))
    else $error("match reported beyond the list end");

endmodule

[rtl/deque_with_linear_search.sv]
// ----------------------------------------------------------------------------
// deque_with_linear_search: bounded deque in a ring store with search
// Top level joining the request sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tuser carries req_type (push front, push back, search),
//   tdata carries the 32-bit value to push or to look for.
//   Master channel: tuser carries status, tdata carries position and the
//   entry count after the request. Every request yields one transaction.
//   Push, full drop, empty search and the unused code: the result is in the
//   output register in the cycle after acceptance; the next request can be
//   taken in that same cycle while the receiver is ready, so these run at one per cycle.
//   Search: the walker reads one entry per cycle from the single memory
//   read port and compares it in the next cycle; the result is loaded on
//   the first match or once the last entry has been compared. Requests are
//   processed one at a time.
//   Reset: head and count go to zero (list empty); store contents are not
//   cleared and need no clearing pass, since only written entries are read.
//   Receiver stall: the result waits in the output register and no new
//   request is taken until it is consumed or consumed in the same cycle.
// ----------------------------------------------------------------------------
module deque_with_linear_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] position, [13:7] count, [15:14] zero
  output logic [2:0]  m_axis_tuser    // [2:0] status
);
  import dqls_pkg::*;

  cmd_t              cmd;
  dp_stat_t          stat;
  logic [OUT_W-1:0]  out_position;
  logic [OUT_W-1:0]  out_count;

  dqls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .req_type (s_axis_tuser),
    .m_ready  (m_axis_tready),
    .stat     (stat),
    .s_ready  (s_axis_tready),
    .cmd      (cmd)
  );

  dqls_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (s_axis_tdata),
    .m_ready      (m_axis_tready),
    .stat         (stat),
    .out_valid    (m_axis_tvalid),
    .out_status   (m_axis_tuser),
    .out_position (out_position),
    .out_count    (out_count)
  );

  // Pack result fields, lowest first, padded to whole bytes
  assign m_axis_tdata = {2'b00, out_count, out_position};

endmodule
